// ----- hdl/cft_pkg.sv -----
// Shared types, constants and the opcode length table of the 65C02 code flow tracer.
// Used by every module of the tracer and by its checker; depends on nothing.
`timescale 1ns / 1ps

package cft_pkg;

	// Opcodes and bytes with a special meaning to the trace.
	localparam logic [7:0] OP_STOP    = 8'hDF;
	localparam logic [7:0] OP_RTS     = 8'h60;
	localparam logic [7:0] OP_JMP_ABS = 8'h4C;
	localparam logic [7:0] OP_BRA     = 8'h80;
	localparam logic [7:0] OP_JSR     = 8'h20;

	// Branch opcodes share this pattern in their low five bits.
	localparam logic [4:0] BRANCH_LOW_BITS = 5'h10;

	// Instruction lengths as the table gives them.
	localparam logic [1:0] LEN_ONE   = 2'd1;
	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	// The whole 64K address space; the limit never reaches past it.
	localparam logic [16:0] FULL_LIMIT = 17'h10000;

	// Configuration port.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 17;
	localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_BASE  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		STOP_NONE     = 2'd0,
		STOP_TRANSFER = 2'd1,
		STOP_BYTE     = 2'd2,
		STOP_RANGE    = 2'd3
	} stop_t;

	// Which byte of an instruction the tracker waits for.
	typedef enum logic [1:0] {
		POS_OPCODE = 2'd0,
		POS_LOW    = 2'd1,
		POS_HIGH   = 2'd2
	} pos_t;

	typedef struct packed {
		logic        first;
		logic [15:0] start_address;
		logic [7:0]  code_byte;
	} code_beat_t;

	typedef struct packed {
		logic [15:0] instr_address;
		logic [7:0]  opcode;
		logic [16:0] next_address;
		logic [15:0] target;
		logic        target_valid;
		logic        is_call;
		stop_t       stop_reason;
	} instr_beat_t;

	// Instruction length of a 65C02 opcode, from its addressing mode.
	function automatic logic [1:0] op_length(input logic [7:0] op);
		logic [3:0] hi;
		logic [3:0] lo;
		logic [1:0] len;
		hi = op[7:4];
		lo = op[3:0];
		case (lo)
			4'h0: begin
				if (hi[0]) begin
					len = LEN_TWO;
				end else begin
					case (hi)
						4'h2:                len = LEN_THREE;
						4'h0, 4'h4, 4'h6:    len = LEN_ONE;
						default:             len = LEN_TWO;
					endcase
				end
			end
			4'h1, 4'h4, 4'h5, 4'h6: len = LEN_TWO;
			4'h2: len = (hi[0] || hi == 4'hA) ? LEN_TWO : LEN_ONE;
			4'h9: len = hi[0] ? LEN_THREE : LEN_TWO;
			4'hC, 4'hD, 4'hE: len = LEN_THREE;
			default: len = LEN_ONE;
		endcase
		return len;
	endfunction

endpackage

// ----- hdl/cft_tracker.sv -----
// Trace state and per-byte decode of the code flow tracer: assembles instructions from
// the byte stream and forms one result per complete instruction. Depends on cft_pkg.
`timescale 1ns / 1ps

module cft_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 beat_valid,
	input  cft_pkg::code_beat_t  beat,
	input  logic [15:0]          range_base,
	input  logic [16:0]          range_limit,
	output logic                 push,
	output cft_pkg::instr_beat_t result
);
	import cft_pkg::*;

	logic        active_q;
	pos_t        pos_q;
	logic [7:0]  held_op_q;
	logic [7:0]  held_low_q;
	logic [15:0] instr_start_q;
	logic [15:0] cur_addr_q;

	logic        active_n;
	pos_t        pos_n;
	logic [7:0]  held_op_n;
	logic [7:0]  held_low_n;
	logic [15:0] instr_start_n;
	logic [15:0] cur_addr_n;

	logic        eff_active;
	pos_t        eff_pos;
	logic [15:0] eff_cur;
	logic [7:0]  b;

	logic        finish;
	logic        stop_byte;
	logic        pos_advance;
	logic [7:0]  fin_op;
	logic [15:0] fin_start;
	logic [7:0]  fin_low;
	logic [7:0]  fin_high;

	logic [16:0] next_addr;
	logic [17:0] dest;
	logic        is_branch;
	logic        is_abs;
	logic        has_dest;
	logic        dest_ok;
	stop_t       stop;

	assign b          = beat.code_byte;
	assign eff_active = beat.first | active_q;
	assign eff_pos    = beat.first ? POS_OPCODE : pos_q;
	assign eff_cur    = beat.first ? beat.start_address : cur_addr_q;

	// Pick the instruction that this byte completes, if any.
	always_comb begin
		finish      = 1'b0;
		stop_byte   = 1'b0;
		pos_advance = 1'b0;
		fin_op      = b;
		fin_start   = eff_cur;
		fin_low     = 8'h00;
		fin_high    = 8'h00;
		if (beat_valid && eff_active) begin
			case (eff_pos)
				POS_OPCODE: begin
					stop_byte = (b == OP_STOP);
					if (stop_byte || op_length(b) == LEN_ONE) begin
						finish = 1'b1;
					end else begin
						pos_advance = 1'b1;
					end
				end
				POS_LOW: begin
					fin_op    = held_op_q;
					fin_start = instr_start_q;
					fin_low   = b;
					if (op_length(held_op_q) == LEN_TWO) begin
						finish = 1'b1;
					end else begin
						pos_advance = 1'b1;
					end
				end
				POS_HIGH: begin
					fin_op    = held_op_q;
					fin_start = instr_start_q;
					fin_low   = held_low_q;
					fin_high  = b;
					finish    = 1'b1;
				end
				default: begin
					finish = 1'b0;
				end
			endcase
		end
	end

	// Length, destination, range check and end-of-trace reason.
	always_comb begin
		is_branch = (fin_op[4:0] == BRANCH_LOW_BITS) || (fin_op == OP_BRA);
		is_abs    = (fin_op == OP_JMP_ABS) || (fin_op == OP_JSR);
		has_dest  = is_branch || is_abs;
		next_addr = {1'b0, fin_start} + {15'd0, op_length(fin_op)};
		if (is_branch) begin
			dest = {1'b0, next_addr} + {{10{fin_low[7]}}, fin_low};
		end else begin
			dest = {2'b00, fin_high, fin_low};
		end
		dest_ok = has_dest && (dest[17:16] == 2'b00) && (dest[15:0] >= range_base)
			&& ({1'b0, dest[15:0]} < range_limit);
		if (stop_byte) begin
			stop = STOP_BYTE;
		end else if (fin_op == OP_RTS || fin_op == OP_JMP_ABS || fin_op == OP_BRA) begin
			stop = STOP_TRANSFER;
		end else if (next_addr >= range_limit) begin
			stop = STOP_RANGE;
		end else begin
			stop = STOP_NONE;
		end
		push                 = finish;
		result.instr_address = fin_start;
		result.opcode        = fin_op;
		result.next_address  = next_addr;
		result.target        = has_dest ? dest[15:0] : 16'h0000;
		result.target_valid  = dest_ok;
		result.is_call       = (fin_op == OP_JSR);
		result.stop_reason   = stop;
	end

	// Next trace state.
	always_comb begin
		active_n      = active_q;
		pos_n         = pos_q;
		held_op_n     = held_op_q;
		held_low_n    = held_low_q;
		instr_start_n = instr_start_q;
		cur_addr_n    = cur_addr_q;
		if (beat_valid && beat.first) begin
			active_n   = 1'b1;
			pos_n      = POS_OPCODE;
			cur_addr_n = beat.start_address;
		end
		if (beat_valid && eff_active && eff_pos == POS_OPCODE) begin
			held_op_n     = b;
			held_low_n    = 8'h00;
			instr_start_n = eff_cur;
		end
		if (beat_valid && eff_active && eff_pos == POS_LOW) begin
			held_low_n = b;
		end
		if (pos_advance) begin
			pos_n = (eff_pos == POS_OPCODE) ? POS_LOW : POS_HIGH;
		end
		if (finish) begin
			pos_n      = POS_OPCODE;
			active_n   = (stop == STOP_NONE);
			cur_addr_n = next_addr[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			pos_q         <= POS_OPCODE;
			held_op_q     <= 8'h00;
			held_low_q    <= 8'h00;
			instr_start_q <= 16'h0000;
			cur_addr_q    <= 16'h0000;
		end else begin
			active_q      <= active_n;
			pos_q         <= pos_n;
			held_op_q     <= held_op_n;
			held_low_q    <= held_low_n;
			instr_start_q <= instr_start_n;
			cur_addr_q    <= cur_addr_n;
		end
	end

endmodule

// ----- hdl/cft_out_buf.sv -----
// Result register with a skid stage, so the byte side keeps moving while a result waits.
// Depends on cft_pkg for the result type.
`timescale 1ns / 1ps

module cft_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cft_pkg::instr_beat_t push_data,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cft_pkg::instr_beat_t out_data
);
	import cft_pkg::*;

	logic        out_valid_q;
	logic        skid_valid_q;
	instr_beat_t out_data_q;
	instr_beat_t skid_data_q;
	logic        pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

endmodule

// ----- hdl/cmos6502_code_flow_tracer.sv -----
// Top level of the 65C02 code flow tracer: configuration registers, trace tracker and
// result buffer. Depends on cft_pkg, cft_tracker and cft_out_buf.
`timescale 1ns / 1ps

// The tracer takes a stream of 65C02 code bytes, one per beat on the byte channel, and
// emits one beat on the instr channel for each complete instruction: its address, opcode,
// the address after it, and for branches, JMP absolute and JSR the destination with an
// in-range flag and a call flag. A beat with first set starts a new trace at its
// start_address and drops any partial instruction; bytes that arrive while no trace is
// running are consumed and ignored. A trace ends on the stop byte 0xDF, on RTS, JMP
// absolute or BRA, or when the next address reaches range_limit, and stop_reason tells
// which. The block takes one byte every cycle unless byte_stall is high: decode is a
// table lookup, an address add and a few compares between the trace state registers
// and the result register, which is backed by a one-entry skid stage, so byte_stall
// rises only after two results sit unclaimed; a result enters the skid while one is stalled.
// Configuration (index 0 range_base, index 1 range_limit) is for the user to write
// while idle, which the block does not enforce; a limit above 65536 is held as 65536.

module cmos6502_code_flow_tracer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	output logic                                byte_stall,
	input  cft_pkg::code_beat_t                 byte_data,
	output logic                                instr_valid,
	input  logic                                instr_stall,
	output cft_pkg::instr_beat_t                instr_data,
	input  logic                                cfg_wr_en,
	input  logic [cft_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cft_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import cft_pkg::*;

	logic [15:0] range_base_q;
	logic [16:0] range_limit_q;
	logic        byte_accept;
	logic        push;
	instr_beat_t result;
	logic        buf_full;

	// The limit is clamped as it is written, so the decode only ever sees 0 to 65536.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_base_q  <= 16'h0000;
			range_limit_q <= FULL_LIMIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_RANGE_BASE: begin
					range_base_q <= cfg_data[15:0];
				end
				CFG_RANGE_LIMIT: begin
					range_limit_q <= (cfg_data > FULL_LIMIT) ? FULL_LIMIT : cfg_data;
				end
				default: begin
					range_base_q <= range_base_q;
				end
			endcase
		end
	end

	// Stall depends only on the skid stage, never on the incoming valid.
	assign byte_stall  = buf_full;
	assign byte_accept = byte_valid && !byte_stall;

	cft_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat_valid  (byte_accept),
		.beat        (byte_data),
		.range_base  (range_base_q),
		.range_limit (range_limit_q),
		.push        (push),
		.result      (result)
	);

	cft_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.full      (buf_full),
		.out_valid (instr_valid),
		.out_stall (instr_stall),
		.out_data  (instr_data)
	);

endmodule

// ----- hdl/cft_checker.sv -----
// Port-level checks of the code flow tracer, bound to its top level.
// Depends on cft_pkg and cmos6502_code_flow_tracer.
`timescale 1ns / 1ps

module cft_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_stall,
	input logic                 instr_valid,
	input logic                 instr_stall,
	input cft_pkg::instr_beat_t instr_data
);
	import cft_pkg::*;

	// The byte side stalls only when a result is already waiting in front of the skid.
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> instr_valid)
		else $error("byte_stall without a waiting result");

	// A stalled result holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		instr_valid && instr_stall |=> instr_valid && $stable(instr_data))
		else $error("stalled result changed or vanished");

	// A stop-byte ending carries the stop byte and no destination.
	assert property (@(posedge clk) disable iff (!arst_n)
		instr_valid && instr_data.stop_reason == STOP_BYTE |->
			instr_data.opcode == OP_STOP && !instr_data.target_valid && !instr_data.is_call)
		else $error("stop byte result malformed");

	// Calls are JSR and transfers are RTS, JMP absolute or BRA.
	assert property (@(posedge clk) disable iff (!arst_n)
		instr_valid && instr_data.stop_reason == STOP_TRANSFER |->
			instr_data.opcode == OP_RTS || instr_data.opcode == OP_JMP_ABS
			|| instr_data.opcode == OP_BRA)
		else $error("transfer stop on wrong opcode");

	assert property (@(posedge clk) disable iff (!arst_n)
		instr_valid && instr_data.is_call |-> instr_data.opcode == OP_JSR)
		else $error("call flag on a non-JSR opcode");

endmodule

bind cmos6502_code_flow_tracer cft_checker u_cft_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.byte_stall  (byte_stall),
	.instr_valid (instr_valid),
	.instr_stall (instr_stall),
	.instr_data  (instr_data)
);

// ----- sim/cmos6502_code_flow_tracer_tb.sv -----
// Self-checking testbench for the 65C02 code flow tracer: a directed opening, then
// random byte streams under several range settings and idling patterns.
// Depends on cft_pkg and the cmos6502_code_flow_tracer top level.
`timescale 1ns / 1ps

module cmos6502_code_flow_tracer_tb;
	import cft_pkg::*;

	// The cycle limit lies far beyond what a healthy run needs.
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int PHASES = 8;

	// The scoreboard keeps its own copy of the trace state and of the two range
	// registers. Every accepted code beat is run through that state, and each
	// instruction it completes is queued; the instr channel must drain the queue
	// in order.
	class flow_checker;
		logic        active;
		pos_t        pos;
		logic [7:0]  op;
		logic [7:0]  low;
		logic [15:0] start;
		logic [16:0] cur_addr;
		logic [15:0] base;
		logic [16:0] limit;
		instr_beat_t expected_instrs[$];
		int          errors;
		int          checked;

		function new();
			active = 1'b0;
			pos = POS_OPCODE;
			op = '0;
			low = '0;
			start = '0;
			cur_addr = '0;
			base = '0;
			limit = FULL_LIMIT;
			errors = 0;
			checked = 0;
		endfunction

		// Opcode lengths, one nibble per low-nibble column, column 0 leftmost.
		function logic [1:0] instr_len(logic [7:0] opc);
			logic [63:0] row;
			case (opc[7:4])
				4'h0, 4'h4, 4'h6:  row = 64'h1211_2221_1211_3331;
				4'h2:              row = 64'h3211_2221_1211_3331;
				4'hA:              row = 64'h2221_2221_1211_3331;
				4'h8, 4'hC, 4'hE:  row = 64'h2211_2221_1211_3331;
				default:           row = 64'h2221_2221_1311_3331;
			endcase
			return row[61 - 4 * opc[3:0] -: 2];
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endfunction

		function string fmt(instr_beat_t r);
			return $sformatf("addr=%h op=%h next=%h target=%h valid=%b call=%b stop=%0d",
				r.instr_address, r.opcode, r.next_address, r.target, r.target_valid,
				r.is_call, r.stop_reason);
		endfunction

		function void set_range(logic [15:0] new_base, logic [16:0] new_limit);
			base = new_base;
			limit = new_limit;
		endfunction

		// Closes the held instruction; hi_byte is the high operand of a 3-byte one.
		function void complete(logic [7:0] hi_byte);
			instr_beat_t r;
			logic [16:0] next_addr;
			logic [16:0] lim;
			int          dest;
			bit          has_dest;
			next_addr = {1'b0, start} + {15'd0, instr_len(op)};
			lim = (limit > FULL_LIMIT) ? FULL_LIMIT : limit;
			has_dest = 1'b1;
			dest = 0;
			if (op[4:0] == BRANCH_LOW_BITS || op == OP_BRA)
				dest = int'(next_addr) + int'($signed(low));
			else if (op == OP_JMP_ABS || op == OP_JSR)
				dest = int'({hi_byte, low});
			else
				has_dest = 1'b0;
			r.instr_address = start;
			r.opcode = op;
			r.next_address = next_addr;
			r.target = has_dest ? dest[15:0] : 16'h0000;
			r.target_valid = has_dest && dest >= 0 && dest <= 65535 &&
				dest >= int'(base) && dest < int'(lim);
			r.is_call = (op == OP_JSR);
			if (op == OP_RTS || op == OP_JMP_ABS || op == OP_BRA)
				r.stop_reason = STOP_TRANSFER;
			else if (next_addr >= lim)
				r.stop_reason = STOP_RANGE;
			else
				r.stop_reason = STOP_NONE;
			cur_addr = next_addr;
			pos = POS_OPCODE;
			active = (r.stop_reason == STOP_NONE);
			expected_instrs.push_back(r);
		endfunction

		function void note_byte(code_beat_t b);
			instr_beat_t r;
			if (b.first) begin
				active = 1'b1;
				pos = POS_OPCODE;
				cur_addr = {1'b0, b.start_address};
			end
			if (!active)
				return;
			case (pos)
				POS_OPCODE: begin
					start = cur_addr[15:0];
					op = b.code_byte;
					low = '0;
					cur_addr = cur_addr + 17'd1;
					if (op == OP_STOP) begin
						r.instr_address = start;
						r.opcode = op;
						r.next_address = {1'b0, start} + 17'd1;
						r.target = '0;
						r.target_valid = 1'b0;
						r.is_call = 1'b0;
						r.stop_reason = STOP_BYTE;
						active = 1'b0;
						expected_instrs.push_back(r);
					end else if (instr_len(op) == LEN_ONE) begin
						complete(8'h00);
					end else begin
						pos = POS_LOW;
					end
				end
				POS_LOW: begin
					cur_addr = cur_addr + 17'd1;
					low = b.code_byte;
					if (instr_len(op) == LEN_TWO)
						complete(8'h00);
					else
						pos = POS_HIGH;
				end
				default: begin
					cur_addr = cur_addr + 17'd1;
					complete(b.code_byte);
				end
			endcase
		endfunction

		function void check_instr(instr_beat_t got);
			instr_beat_t want;
			if (expected_instrs.size() == 0) begin
				report({"unexpected instruction ", fmt(got)});
				return;
			end
			want = expected_instrs.pop_front();
			checked++;
			if (got.instr_address !== want.instr_address || got.opcode !== want.opcode ||
			    got.next_address !== want.next_address || got.target !== want.target ||
			    got.target_valid !== want.target_valid || got.is_call !== want.is_call ||
			    got.stop_reason !== want.stop_reason)
				report({"expected ", fmt(want), " got ", fmt(got)});
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   byte_valid = 1'b0;
	logic                   byte_stall;
	code_beat_t             byte_data = '0;
	logic                   instr_valid;
	logic                   instr_stall = 1'b0;
	instr_beat_t            instr_data;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_RANGE_BASE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	flow_checker tracer;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          beats_sent = 0;
	int          settings_used = 0;
	logic [16:0] cur_limit = FULL_LIMIT;

	cmos6502_code_flow_tracer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.instr_data  (instr_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The run is cut off here if the handshakes ever stop making progress.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver side. Right after the rising edge every signal still holds the value
	// the block saw at that edge, so a beat counts when valid was high and our own
	// stall was low. The stall for the next cycle is then drawn at random.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && instr_valid === 1'b1 && !instr_stall)
			tracer.check_instr(instr_data);
		instr_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Offers one code beat, after a random idle gap, and holds it until accepted.
	// Valid is left high on return so that back-to-back beats never drop it.
	task automatic send_byte(input code_beat_t b);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		byte_valid <= 1'b1;
		byte_data <= b;
		do @(posedge clk); while (byte_stall);
		tracer.note_byte(b);
		beats_sent++;
	endtask

	task automatic send(input logic first, input logic [15:0] addr, input logic [7:0] code);
		code_beat_t b;
		b.first = first;
		b.start_address = addr;
		b.code_byte = code;
		send_byte(b);
	endtask

	// Stops sending until every predicted instruction has come out. A trailing
	// operand byte produces nothing, so the task then waits on to let the block settle.
	task automatic drain_results();
		byte_valid <= 1'b0;
		while (tracer.expected_instrs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both range registers are written back to back while the block is idle.
	task automatic configure(input logic [15:0] new_base, input logic [16:0] new_limit);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_RANGE_BASE;
		cfg_data <= {1'b0, new_base};
		@(posedge clk);
		cfg_index <= CFG_RANGE_LIMIT;
		cfg_data <= new_limit;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracer.set_range(new_base, new_limit);
		cur_limit = (new_limit > FULL_LIMIT) ? FULL_LIMIT : new_limit;
		settings_used++;
	endtask

	// Terminating opcodes and branches are favored so that traces stay short and
	// every way of ending one comes up often.
	function automatic logic [7:0] pick_opcode();
		logic [2:0] row;
		int         v;
		row = 3'($urandom_range(0, 7));
		v = $urandom_range(0, 255);
		case ($urandom_range(0, 15))
			0:       return OP_RTS;
			1:       return OP_JMP_ABS;
			2:       return OP_BRA;
			3:       return OP_JSR;
			4:       return OP_STOP;
			5, 6:    return {row, BRANCH_LOW_BITS};
			default: return v[7:0];
		endcase
	endfunction

	// Half of the traces start just below the limit so that range ends are common.
	function automatic logic [15:0] pick_start();
		int s;
		s = $urandom_range(0, 65535);
		if ($urandom_range(0, 1))
			return s[15:0];
		s = int'(cur_limit) - int'($urandom_range(1, 6));
		if (s < 0)
			s = $urandom_range(0, 6);
		return s[15:0];
	endfunction

	// Random part of one phase. Most beats continue a live trace; a trace that has
	// ended is usually restarted, sometimes fed a byte that must be ignored, and now
	// and then a live trace is cut off by a restart, at times in the middle of an instruction.
	task automatic run_phase(input int n_items);
		code_beat_t b;
		int         counted;
		int         pause_at;
		int         v;
		counted = 0;
		pause_at = $urandom_range(0, n_items - 1);
		while (counted < n_items) begin
			if (counted == pause_at) begin
				drain_results();
				pause_at = -1;
			end
			v = $urandom;
			b.start_address = v[15:0];
			b.code_byte = v[23:16];
			b.first = 1'b0;
			if (!tracer.active)
				b.first = ($urandom_range(0, 9) != 0);
			else if ($urandom_range(0, 29) == 0)
				b.first = 1'b1;
			if (b.first)
				b.start_address = pick_start();
			if (b.first || (tracer.active && tracer.pos == POS_OPCODE))
				b.code_byte = pick_opcode();
			if (b.first || tracer.active)
				counted++;
			send_byte(b);
		end
	endtask

	initial begin
		logic [15:0] ph_base;
		logic [16:0] ph_limit;
		int          v;
		int          waited;
		tracer = new();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, with the reset range first.
		configure(16'h0000, FULL_LIMIT);
		// A beat while no trace runs is swallowed without a result.
		send(1'b0, 16'hFFFF, 8'hEA);
		// JSR records its destination and the call flag.
		send(1'b1, 16'h0000, OP_JSR);
		send(1'b0, 16'h0000, 8'h34);
		send(1'b0, 16'h0000, 8'h12);
		send(1'b0, 16'h0000, 8'hEA);
		// A backward branch of -128 lands below address zero.
		send(1'b0, 16'h0000, 8'hD0);
		send(1'b0, 16'h0000, 8'h80);
		send(1'b0, 16'h0000, 8'h10);
		send(1'b0, 16'h0000, 8'h7F);
		send(1'b0, 16'h0000, 8'h00);
		send(1'b0, 16'h0000, 8'hFF);
		// A restart drops the half-received LDA absolute; the JMP that follows
		// crosses the end of memory, and the transfer wins over the range end.
		send(1'b0, 16'h0000, 8'hAD);
		send(1'b0, 16'h0000, 8'h00);
		send(1'b1, 16'hFFFE, OP_JMP_ABS);
		send(1'b0, 16'h0000, 8'hFF);
		send(1'b0, 16'h0000, 8'hFF);
		// The stop byte on the very last address.
		send(1'b1, 16'hFFFF, OP_STOP);
		// BRA forward past the top of memory.
		send(1'b1, 16'hFFFD, OP_BRA);
		send(1'b0, 16'h0000, 8'h7F);
		// JMP indirect and RTI carry no destination and keep the trace going.
		send(1'b1, 16'h8000, 8'h6C);
		send(1'b0, 16'h0000, 8'h00);
		send(1'b0, 16'h0000, 8'h90);
		send(1'b0, 16'h0000, 8'h40);
		send(1'b0, 16'h0000, OP_RTS);
		// A start beyond a zero limit still decodes one instruction.
		configure(16'hFFFF, 17'h00000);
		send(1'b1, 16'h1234, 8'hEA);
		// An oversized limit behaves as the full address space.
		configure(16'h0000, 17'h1FFFF);
		send(1'b1, 16'hFFF0, OP_JMP_ABS);
		send(1'b0, 16'h0000, 8'hFF);
		send(1'b0, 16'h0000, 8'hFF);

		// Random phases. The idling pattern cycles through none, sender only,
		// receiver only and both, while the range takes its extremes in some phases and random values in others.
		for (int ph = 0; ph < PHASES; ph++) begin
			v = $urandom;
			ph_base = v[15:0];
			ph_limit = 17'($urandom_range(0, 17'h1FFFF));
			case (ph)
				0: begin ph_base = 16'h0000; ph_limit = FULL_LIMIT; end
				1: begin ph_base = 16'hFFFF; ph_limit = 17'h1FFFF; end
				2: begin ph_base = 16'h0000; ph_limit = 17'h00000; end
				4: begin ph_base = 16'h4000; ph_limit = 17'h0C000; end
				6: begin ph_base = 16'h0000; ph_limit = 17'h1FFFF; end
				7: ph_limit = FULL_LIMIT;
				default: ;
			endcase
			configure(ph_base, ph_limit);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			run_phase(ITEMS_PER_PHASE);
		end

		// Let the last instructions come out, then wait on in quiet for strays.
		byte_valid <= 1'b0;
		waited = 0;
		while (tracer.expected_instrs.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (tracer.expected_instrs.size() != 0)
			tracer.report($sformatf("%0d predicted instructions never came out",
				tracer.expected_instrs.size()));

		$display("Summary: %0d code beats in, %0d instructions compared, %0d range settings,",
			beats_sent, tracer.checked, settings_used);
		$display("Summary: four idling patterns, %0d failures in total.", tracer.errors);
		if (tracer.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/cft_pkg.sv
hdl/cft_tracker.sv
hdl/cft_out_buf.sv
hdl/cmos6502_code_flow_tracer.sv
hdl/cft_checker.sv
sim/cmos6502_code_flow_tracer_tb.sv
